// ===== src/rnsc_pkg.sv =====
`default_nettype none

package rnsc_pkg;

   localparam int BASE_W  = 9;
   localparam int DIGIT_W = 10;
   localparam int KIND_W  = 3;

   localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(500);
   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

   localparam logic [KIND_W-1:0] TOKEN_DIGIT = KIND_W'(0);
   localparam logic [KIND_W-1:0] TOKEN_POINT = KIND_W'(1);
   localparam logic [KIND_W-1:0] TOKEN_OPEN  = KIND_W'(2);
   localparam logic [KIND_W-1:0] TOKEN_CLOSE = KIND_W'(3);

   localparam logic CSR_SOURCE_BASE = 1'b0;
   localparam logic CSR_TARGET_BASE = 1'b1;

   typedef enum logic [2:0] {
      PH_INT        = 3'd0,
      PH_AFTER_PT   = 3'd1,
      PH_FRAC       = 3'd2,
      PH_AFTER_OPEN = 3'd3,
      PH_PERIOD     = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_SOURCE_BASE  = 4'd1,
      ERR_TARGET_BASE  = 4'd2,
      ERR_DIGIT        = 4'd3,
      ERR_SECOND_POINT = 4'd4,
      ERR_SECOND_OPEN  = 4'd5,
      ERR_OPEN_NO_PT   = 4'd6,
      ERR_CLOSE_NO_OPN = 4'd7,
      ERR_EMPTY_PERIOD = 4'd8,
      ERR_AFTER_CLOSE  = 4'd9,
      ERR_UNKNOWN      = 4'd10,
      ERR_UNCLOSED     = 4'd11,
      ERR_EMPTY_FRAC   = 4'd12,
      ERR_NO_INTEGER   = 4'd13
   } err_type;

endpackage

`default_nettype wire

// ===== src/radix_number_syntax_checker_core.sv =====
// Checks the syntax of a number in a programmable radix, one token per request. A request
// carries a token kind (digit, point, open or close period bracket), a digit value and a
// last-token flag. The first error is held and later tokens are ignored; the request marked
// last returns one response with number_ok, a dense error code and, for a digit that is too
// large, the offending digit value. Requests that are not last return nothing. Both radix
// registers must lie in 2..500 and are checked before every token; write them only while
// no number is in progress. The block takes one request per cycle and answers a last token in
// the next cycle, from a single response register. While that register holds
// a response that is stalled, requests that are not last are still taken; a last token
// waits.
`default_nettype none

module radix_number_syntax_checker_core (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_write_enable,
   input  wire                             csr_index,
   input  wire [rnsc_pkg::BASE_W-1:0]      csr_write_data,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [rnsc_pkg::KIND_W-1:0]      req_token_kind,
   input  wire [rnsc_pkg::DIGIT_W-1:0]     req_digit_value,
   input  wire                             req_last_token,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_number_ok,
   output logic [3:0]                      rsp_error_code,
   output logic [rnsc_pkg::DIGIT_W-1:0]    rsp_bad_digit
);
   import rnsc_pkg::*;

   logic [BASE_W-1:0]  source_base_ff;
   logic [BASE_W-1:0]  target_base_ff;

   phase_type          phase_ff, phase_in;
   logic               point_seen_ff, point_seen_in;
   logic               open_seen_ff, open_seen_in;
   logic               close_seen_ff, close_seen_in;
   logic               int_digit_ff, int_digit_in;
   err_type            latched_error_ff, latched_error_in;
   logic [DIGIT_W-1:0] latched_digit_ff, latched_digit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_number_ok_ff;
   err_type            rsp_error_code_ff;
   logic [DIGIT_W-1:0] rsp_bad_digit_ff;

   logic               accept;
   logic               src_ok;
   logic               tgt_ok;
   err_type            err_tok;
   err_type            err_final;

   // The digit that caused a digit error, before the end-of-number clear wipes it.
   function automatic logic [DIGIT_W-1:0] latched_digit_in_pre();
      logic [DIGIT_W-1:0] d;
      d = latched_digit_ff;
      if (latched_error_ff == ERR_NONE) begin
         d = req_digit_value;
      end
      return d;
   endfunction

   // Only a last token needs the response register, so only it waits on a stalled response.
   assign req_stall = rsp_valid_ff & rsp_stall & req_last_token;
   assign accept    = req_valid & ~req_stall;

   assign src_ok = (source_base_ff >= BASE_MIN) && (source_base_ff <= BASE_MAX);
   assign tgt_ok = (target_base_ff >= BASE_MIN) && (target_base_ff <= BASE_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_base_ff <= BASE_RESET;
         target_base_ff <= BASE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_BASE: source_base_ff <= csr_write_data;
            CSR_TARGET_BASE: target_base_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      point_seen_in    = point_seen_ff;
      open_seen_in     = open_seen_ff;
      close_seen_in    = close_seen_ff;
      int_digit_in     = int_digit_ff;
      latched_digit_in = latched_digit_ff;
      err_tok          = latched_error_ff;

      if (latched_error_ff == ERR_NONE) begin
         if (!src_ok) begin
            err_tok = ERR_SOURCE_BASE;
         end else if (!tgt_ok) begin
            err_tok = ERR_TARGET_BASE;
         end else begin
            case (req_token_kind)
               TOKEN_DIGIT: begin
                  if (req_digit_value >= {1'b0, source_base_ff}) begin
                     err_tok          = ERR_DIGIT;
                     latched_digit_in = req_digit_value;
                  end else if (phase_ff == PH_INT) begin
                     int_digit_in = 1'b1;
                  end else if (phase_ff == PH_AFTER_PT) begin
                     phase_in = PH_FRAC;
                  end else if (phase_ff == PH_AFTER_OPEN) begin
                     phase_in = PH_PERIOD;
                  end
               end
               TOKEN_POINT: begin
                  if (point_seen_ff) begin
                     err_tok = ERR_SECOND_POINT;
                  end else begin
                     point_seen_in = 1'b1;
                     phase_in      = PH_AFTER_PT;
                  end
               end
               TOKEN_OPEN: begin
                  if (open_seen_ff) begin
                     err_tok = ERR_SECOND_OPEN;
                  end else if (!point_seen_ff) begin
                     err_tok = ERR_OPEN_NO_PT;
                  end else begin
                     open_seen_in = 1'b1;
                     phase_in     = PH_AFTER_OPEN;
                  end
               end
               TOKEN_CLOSE: begin
                  if (!open_seen_ff) begin
                     err_tok = ERR_CLOSE_NO_OPN;
                  end else if (phase_ff != PH_PERIOD) begin
                     err_tok = ERR_EMPTY_PERIOD;
                  end else begin
                     close_seen_in = 1'b1;
                     if (!req_last_token) begin
                        err_tok = ERR_AFTER_CLOSE;
                     end
                  end
               end
               default: err_tok = ERR_UNKNOWN;
            endcase
         end
      end

      // End-of-number checks look at the state as this token leaves it.
      err_final = err_tok;
      if (err_tok == ERR_NONE) begin
         if (open_seen_in && !close_seen_in) begin
            err_final = ERR_UNCLOSED;
         end else if (point_seen_in && phase_in == PH_AFTER_PT) begin
            err_final = ERR_EMPTY_FRAC;
         end else if (!int_digit_in) begin
            err_final = ERR_NO_INTEGER;
         end
      end

      latched_error_in = err_tok;
      if (req_last_token) begin
         phase_in         = PH_INT;
         point_seen_in    = 1'b0;
         open_seen_in     = 1'b0;
         close_seen_in    = 1'b0;
         int_digit_in     = 1'b0;
         latched_error_in = ERR_NONE;
         latched_digit_in = '0;
      end

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept && req_last_token) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_INT;
         point_seen_ff    <= 1'b0;
         open_seen_ff     <= 1'b0;
         close_seen_ff    <= 1'b0;
         int_digit_ff     <= 1'b0;
         latched_error_ff <= ERR_NONE;
         latched_digit_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            point_seen_ff    <= point_seen_in;
            open_seen_ff     <= open_seen_in;
            close_seen_ff    <= close_seen_in;
            int_digit_ff     <= int_digit_in;
            latched_error_ff <= latched_error_in;
            latched_digit_ff <= latched_digit_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_token) begin
         rsp_number_ok_ff  <= (err_final == ERR_NONE);
         rsp_error_code_ff <= err_final;
         rsp_bad_digit_ff  <= (err_final == ERR_DIGIT) ? latched_digit_in_pre() : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_number_ok  = rsp_number_ok_ff;
   assign rsp_error_code = rsp_error_code_ff;
   assign rsp_bad_digit  = rsp_bad_digit_ff;

endmodule

`default_nettype wire

// ===== src/rnsc_checker.sv =====
`default_nettype none

module rnsc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          req_last_token,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire                          rsp_number_ok,
   input wire [3:0]                    rsp_error_code,
   input wire [rnsc_pkg::DIGIT_W-1:0]  rsp_bad_digit
);
   import rnsc_pkg::*;

   // A taken last token always produces a response on the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_token |=> rsp_valid)
      else $error("last token did not produce a response");

   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_number_ok == (rsp_error_code == ERR_NONE)))
      else $error("number_ok disagrees with error code");

   a_bad_digit_only_on_digit_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bad_digit != '0) |-> (rsp_error_code == ERR_DIGIT))
      else $error("bad digit reported without a digit error");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code <= ERR_NO_INTEGER))
      else $error("error code out of range");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_error_code)
         && $stable(rsp_bad_digit) && $stable(rsp_number_ok))
      else $error("stalled response changed");

endmodule

bind radix_number_syntax_checker_core rnsc_checker u_rnsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last_token (req_last_token),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_number_ok  (rsp_number_ok),
   .rsp_error_code (rsp_error_code),
   .rsp_bad_digit  (rsp_bad_digit)
);

`default_nettype wire
